>>> rtl/spm_pkg.sv
// Shared types and constants for the semaphore pool manager.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    localparam int DEF_NUM_SEMAPHORES = 32;
    localparam int DEF_NUM_ENVS       = 1024;
    localparam int DEF_COUNT_BITS     = 16;

    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 6;
    localparam int INIT_W    = 16;
    localparam int ENV_IN_W  = 10;
    localparam int STATUS_W  = 2;
    localparam int GRANT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_POST  = 2'd2,
        OP_WAIT  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic link_rd;
        logic commit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_link;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/spm_req_if.sv
// Request channel: valid/ready handshake with the request payload.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spm_req_if;
    logic                          valid;
    logic                          ready;
    logic [spm_pkg::OP_W-1:0]      operation;
    logic [spm_pkg::HANDLE_W-1:0]  handle;
    logic [spm_pkg::INIT_W-1:0]    initial_count;
    logic [spm_pkg::ENV_IN_W-1:0]  caller_env;

    modport source (output valid, operation, handle, initial_count, caller_env, input ready);
    modport sink   (input valid, operation, handle, initial_count, caller_env, output ready);
endinterface

`default_nettype wire

>>> rtl/spm_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spm_pkg::STATUS_W-1:0]  status;
    logic [spm_pkg::GRANT_W-1:0]   granted_handle;
    logic                          woken_valid;
    logic [spm_pkg::ENV_IN_W-1:0]  woken_env;
    logic                          caller_blocked;

    modport source (output valid, status, granted_handle, woken_valid, woken_env,
                    caller_blocked, input ready);
    modport sink   (input valid, status, granted_handle, woken_valid, woken_env,
                    caller_blocked, output ready);
endinterface

`default_nettype wire

>>> rtl/spm_ctrl.sv
// Request sequencer: accept, optional waiter link read, commit.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire spm_pkg::t_dp_status i_dp_stat,
    output spm_pkg::t_ctrl_cmd       o_cmd
);
    import spm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_dp_stat.need_link) begin
                    n_state = S_LINK;
                end else if (i_dp_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (i_dp_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.link_rd = i_dp_stat.need_link;
                o_cmd.commit  = !i_dp_stat.need_link && i_dp_stat.out_free;
            end
            S_LINK: begin
                o_cmd.commit = i_dp_stat.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/spm_datapath.sv
// Semaphore, free-list and waiter-link memories, request and result registers.
// Depends on spm_pkg; driven by spm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module spm_datapath #(
    parameter int NUM_SEMAPHORES = spm_pkg::DEF_NUM_SEMAPHORES,
    parameter int NUM_ENVS       = spm_pkg::DEF_NUM_ENVS,
    parameter int COUNT_BITS     = spm_pkg::DEF_COUNT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire spm_pkg::t_ctrl_cmd           i_cmd,
    output spm_pkg::t_dp_status               o_dp_stat,
    input  wire logic [spm_pkg::OP_W-1:0]     i_operation,
    input  wire logic [spm_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic [spm_pkg::INIT_W-1:0]   i_initial_count,
    input  wire logic [spm_pkg::ENV_IN_W-1:0] i_caller_env,
    input  wire logic                         i_rsp_ready,
    output logic                              o_rsp_valid,
    output logic [spm_pkg::STATUS_W-1:0]      o_rsp_status,
    output logic [spm_pkg::GRANT_W-1:0]       o_rsp_granted_handle,
    output logic                              o_rsp_woken_valid,
    output logic [spm_pkg::ENV_IN_W-1:0]      o_rsp_woken_env,
    output logic                              o_rsp_caller_blocked
);
    import spm_pkg::*;

    localparam int SEM_W = $clog2(NUM_SEMAPHORES);
    localparam int FH_W  = $clog2(NUM_SEMAPHORES + 1);
    localparam int ENV_W = $clog2(NUM_ENVS);
    localparam logic [FH_W-1:0]       FH_END  = FH_W'(NUM_SEMAPHORES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                  head_valid;
        logic [ENV_W-1:0]      head_env;
        logic [COUNT_BITS-1:0] count;
    } t_sem_word;

    typedef struct packed {
        logic             valid;
        logic [ENV_W-1:0] next;
    } t_link_word;

    // request registers
    t_op                 r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [INIT_W-1:0]   r_init;
    logic [ENV_IN_W-1:0] r_env;

    // memories and their read registers
    t_sem_word   r_sem_mem  [NUM_SEMAPHORES];
    logic [FH_W-1:0] r_fn_mem [NUM_SEMAPHORES];
    t_link_word  r_link_mem [NUM_ENVS];
    t_sem_word   r_sem_rd;
    logic [FH_W-1:0] r_fn_rd;
    t_link_word  r_link_rd;

    // per-handle flags and free list head
    logic [NUM_SEMAPHORES-1:0] r_in_use;
    // handles at or above r_fresh have never left the free list
    logic [FH_W-1:0]           r_fresh;
    logic [FH_W-1:0]           r_free_head;
    logic [FH_W-1:0]           n_free_head;

    // result register
    logic                r_out_valid;
    logic                n_out_valid;
    t_status             r_out_status;
    t_status             n_out_status;
    logic [GRANT_W-1:0]  r_out_granted;
    logic [GRANT_W-1:0]  n_out_granted;
    logic                r_out_wvalid;
    logic                n_out_wvalid;
    logic [ENV_IN_W-1:0] r_out_wenv;
    logic [ENV_IN_W-1:0] n_out_wenv;
    logic                r_out_blocked;
    logic                n_out_blocked;

    logic [SEM_W-1:0] sem_rd_addr;
    logic [SEM_W-1:0] h_idx;
    logic [SEM_W-1:0] s_idx;
    logic [ENV_W-1:0] env_idx;
    logic             h_ok;
    logic             env_ok;
    logic             list_empty;
    logic             sem_we;
    logic [SEM_W-1:0] sem_waddr;
    t_sem_word        sem_wdata;
    logic             fn_we;
    logic             link_we;
    logic [ENV_W-1:0] link_waddr;
    t_link_word       link_wdata;
    logic             use_set;
    logic             use_clr;
    logic             fresh_take;

    assign sem_rd_addr = (t_op'(i_operation) == OP_OPEN) ? SEM_W'(r_free_head)
                                                         : SEM_W'(i_handle);
    assign h_idx      = SEM_W'(r_handle);
    assign s_idx      = SEM_W'(r_free_head);
    assign env_idx    = ENV_W'(r_env);
    assign h_ok       = (32'(r_handle) < 32'(NUM_SEMAPHORES)) && r_in_use[h_idx];
    assign env_ok     = 32'(r_env) < 32'(NUM_ENVS);
    assign list_empty = r_free_head >= FH_END;

    assign o_dp_stat.need_link = (r_op == OP_POST) && h_ok && r_sem_rd.head_valid;
    assign o_dp_stat.out_free  = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_operation);
            r_handle <= i_handle;
            r_init   <= i_initial_count;
            r_env    <= i_caller_env;
            r_sem_rd <= r_sem_mem[sem_rd_addr];
            r_fn_rd  <= r_fn_mem[SEM_W'(r_free_head)];
        end
        if (i_cmd.link_rd) begin
            r_link_rd <= r_link_mem[r_sem_rd.head_env];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && sem_we)  r_sem_mem[sem_waddr]   <= sem_wdata;
        if (i_cmd.commit && fn_we)   r_fn_mem[h_idx]        <= r_free_head;
        if (i_cmd.commit && link_we) r_link_mem[link_waddr] <= link_wdata;
    end

    always_comb begin
        n_out_status  = ST_OK;
        n_out_granted = '0;
        n_out_wvalid  = 1'b0;
        n_out_wenv    = '0;
        n_out_blocked = 1'b0;
        n_free_head   = r_free_head;
        sem_we        = 1'b0;
        sem_waddr     = h_idx;
        sem_wdata     = r_sem_rd;
        fn_we         = 1'b0;
        link_we       = 1'b0;
        link_waddr    = env_idx;
        link_wdata    = '{valid: r_sem_rd.head_valid, next: r_sem_rd.head_env};
        use_set       = 1'b0;
        use_clr       = 1'b0;
        fresh_take    = 1'b0;
        case (r_op)
            OP_OPEN: begin
                if (list_empty) begin
                    n_out_status = ST_NO_FREE;
                end else begin
                    sem_we          = 1'b1;
                    sem_waddr       = s_idx;
                    sem_wdata       = '0;
                    sem_wdata.count = COUNT_BITS'(r_init);
                    use_set         = 1'b1;
                    fresh_take      = (r_free_head == r_fresh);
                    n_free_head     = fresh_take ? r_free_head + FH_W'(1) : r_fn_rd;
                    n_out_granted   = GRANT_W'(r_free_head);
                end
            end
            OP_CLOSE: begin
                if (!h_ok) begin
                    n_out_status = ST_INVALID;
                end else begin
                    use_clr     = 1'b1;
                    fn_we       = 1'b1;
                    n_free_head = FH_W'(h_idx);
                end
            end
            OP_POST: begin
                if (!h_ok) begin
                    n_out_status = ST_INVALID;
                end else if (r_sem_rd.head_valid) begin
                    n_out_wvalid         = 1'b1;
                    n_out_wenv           = ENV_IN_W'(r_sem_rd.head_env);
                    sem_we               = 1'b1;
                    sem_wdata.head_valid = r_link_rd.valid;
                    sem_wdata.head_env   = r_link_rd.next;
                    link_we              = 1'b1;
                    link_waddr           = r_sem_rd.head_env;
                    link_wdata           = '0;
                end else if (r_sem_rd.count != CNT_MAX) begin
                    sem_we          = 1'b1;
                    sem_wdata.count = r_sem_rd.count + COUNT_BITS'(1);
                end
            end
            OP_WAIT: begin
                if (!h_ok) begin
                    n_out_status = ST_INVALID;
                end else if (r_sem_rd.count != '0) begin
                    sem_we          = 1'b1;
                    sem_wdata.count = r_sem_rd.count - COUNT_BITS'(1);
                end else if (!env_ok) begin
                    n_out_status = ST_INVALID;
                end else begin
                    link_we              = 1'b1;
                    sem_we               = 1'b1;
                    sem_wdata.head_valid = 1'b1;
                    sem_wdata.head_env   = env_idx;
                    n_out_blocked        = 1'b1;
                end
            end
            default: n_out_status = ST_INVALID;
        endcase
    end

    always_comb begin
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.commit) begin
                r_free_head <= n_free_head;
                if (use_set)    r_in_use[s_idx] <= 1'b1;
                if (use_clr)    r_in_use[h_idx] <= 1'b0;
                if (fresh_take) r_fresh <= r_fresh + FH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status  <= n_out_status;
            r_out_granted <= n_out_granted;
            r_out_wvalid  <= n_out_wvalid;
            r_out_wenv    <= n_out_wenv;
            r_out_blocked <= n_out_blocked;
        end
    end

    assign o_rsp_valid          = r_out_valid;
    assign o_rsp_status         = r_out_status;
    assign o_rsp_granted_handle = r_out_granted;
    assign o_rsp_woken_valid    = r_out_wvalid;
    assign o_rsp_woken_env      = r_out_wenv;
    assign o_rsp_caller_blocked = r_out_blocked;

endmodule

`default_nettype wire

>>> rtl/semaphore_pool_manager_unit.sv
// Semaphore pool manager top level. Depends on spm_pkg, spm_req_if, spm_rsp_if,
// spm_ctrl and spm_datapath.
// Steps: accept, then execute, which commits and registers the result; a post
// that wakes a waiter reads the waiter-link memory and commits in a link state.
// A new request is accepted only after the last one commits; a full result
// register holds the commit. Reset (synchronous): all handles closed, free list
// 0..N-1 in order, no clearing pass; the waiter-link memory is not reset.
`timescale 1ns / 1ps
`default_nettype none

module semaphore_pool_manager_unit #(
    parameter int NUM_SEMAPHORES = spm_pkg::DEF_NUM_SEMAPHORES,
    parameter int NUM_ENVS       = spm_pkg::DEF_NUM_ENVS,
    parameter int COUNT_BITS     = spm_pkg::DEF_COUNT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spm_req_if.sink    i_req,
    spm_rsp_if.source  o_rsp
);
    import spm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status dp_stat;

    spm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_dp_stat   (dp_stat),
        .o_cmd       (cmd)
    );

    spm_datapath #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .NUM_ENVS       (NUM_ENVS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_dp_stat            (dp_stat),
        .i_operation          (i_req.operation),
        .i_handle             (i_req.handle),
        .i_initial_count      (i_req.initial_count),
        .i_caller_env         (i_req.caller_env),
        .i_rsp_ready          (o_rsp.ready),
        .o_rsp_valid          (o_rsp.valid),
        .o_rsp_status         (o_rsp.status),
        .o_rsp_granted_handle (o_rsp.granted_handle),
        .o_rsp_woken_valid    (o_rsp.woken_valid),
        .o_rsp_woken_env      (o_rsp.woken_env),
        .o_rsp_caller_blocked (o_rsp.caller_blocked)
    );

endmodule

`default_nettype wire
